// File: src/sell_pkg.sv
// ---------------------------------------------------------------------------
// sell_pkg
// Shared types, constants and arithmetic helpers of the sliced ELL engine.
// ---------------------------------------------------------------------------
`default_nettype none
package sell_pkg;

  localparam int VECTOR_DEPTH = 4096;
  localparam int ADDR_W       = $clog2(VECTOR_DEPTH);
  localparam int MAX_SLICE    = 32;
  localparam int MAX_WIDTH    = 255;

  // Item function codes.
  typedef enum logic [1:0] {
    FUNC_LOAD_X = 2'd0,
    FUNC_LOAD_Y = 2'd1,
    FUNC_CHUNK  = 2'd2,
    FUNC_SLOT   = 2'd3
  } func_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_ALPHA  = 2'd0,
    CFG_BETA   = 2'd1,
    CFG_ROWS   = 2'd2,
    CFG_SLICE  = 2'd3
  } cfg_idx_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHUNK,
    ST_CHUNK_CHK,
    ST_SLOT_MUL,
    ST_SLOT_ACC,
    ST_ROW_MUL_A,
    ST_ROW_MUL_B,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic chunk_setup;
    logic chunk_open;
    logic slot_mul;
    logic slot_acc;
    logic row_alpha;
    logic row_beta;
    logic row_emit;
    logic row_advance;
    logic last;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic chunk_is_open;
    logic base_past_limit;
    logic width_zero;
    logic slot_end;
    logic row_in_range;
    logic more_rows;
    logic out_free;
  } stat_t;

  // Round a Q32.32 product to Q16.16: add one half, then floor shift.
  function automatic logic signed [63:0] round_q16(input logic signed [63:0] p);
    logic signed [63:0] t;
    t = p + 64'sd32768;
    return t >>> 16;
  endfunction

  // Saturate to the signed 32-bit range.
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage
`default_nettype wire

// File: src/sell_in_if.sv
// ---------------------------------------------------------------------------
// sell_in_if
// Input item channel: valid/ready handshake with the item fields.
// ---------------------------------------------------------------------------
`default_nettype none
interface sell_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [11:0] load_index;
  logic signed [31:0] load_value;
  logic [11:0] chunk_index;
  logic [7:0]  chunk_slots;
  logic signed [12:0] column;
  logic signed [31:0] entry_value;

  modport source (output valid, func, load_index, load_value, chunk_index,
                  chunk_slots, column, entry_value, input ready);
  modport sink (input valid, func, load_index, load_value, chunk_index,
                chunk_slots, column, entry_value, output ready);
endinterface
`default_nettype wire

// File: src/sell_out_if.sv
// ---------------------------------------------------------------------------
// sell_out_if
// Result item channel: valid/ready handshake with the row result fields.
// ---------------------------------------------------------------------------
`default_nettype none
interface sell_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] row_index;
  logic signed [31:0] row_result;
  logic        last;

  modport source (output valid, row_index, row_result, last, input ready);
  modport sink (input valid, row_index, row_result, last, output ready);
endinterface
`default_nettype wire

// File: src/sell_ctrl.sv
// ---------------------------------------------------------------------------
// sell_ctrl
// Controller state machine: sequences item decode, slot accumulation and
// the row result computation over the shared multiplier.
// ---------------------------------------------------------------------------
`default_nettype none
module sell_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [1:0]    in_func,
  output logic               in_ready,
  input  wire sell_pkg::stat_t stat,
  output sell_pkg::cmd_t     cmd
);
  import sell_pkg::*;

  state_t state_r, state_nxt;
  logic   zw_r, zw_nxt;

  // State register and zero-width chunk flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      zw_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      zw_r    <= zw_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    zw_nxt    = zw_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (func_t'(in_func))
            FUNC_CHUNK: state_nxt = ST_CHUNK;
            FUNC_SLOT:  state_nxt = stat.chunk_is_open ? ST_SLOT_MUL : ST_IDLE;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_CHUNK: state_nxt = ST_CHUNK_CHK;
      ST_CHUNK_CHK: begin
        if (stat.base_past_limit) begin
          state_nxt = ST_IDLE;
        end else if (stat.width_zero) begin
          state_nxt = ST_ROW_MUL_A;
          zw_nxt    = 1'b1;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SLOT_MUL: state_nxt = ST_SLOT_ACC;
      ST_SLOT_ACC: begin
        if (stat.slot_end && stat.row_in_range) begin
          state_nxt = ST_ROW_MUL_A;
          zw_nxt    = 1'b0;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ROW_MUL_A: state_nxt = ST_ROW_MUL_B;
      ST_ROW_MUL_B: state_nxt = ST_FINISH;
      ST_FINISH: begin
        if (stat.out_free) begin
          state_nxt = (zw_r && stat.more_rows) ? ST_ROW_MUL_A : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_CHUNK:     cmd.chunk_setup = 1'b1;
      ST_CHUNK_CHK: cmd.chunk_open = !stat.base_past_limit && !stat.width_zero;
      ST_SLOT_MUL:  cmd.slot_mul = 1'b1;
      ST_SLOT_ACC: begin
        cmd.slot_acc    = 1'b1;
        cmd.row_advance = stat.slot_end && !stat.row_in_range;
      end
      ST_ROW_MUL_A: cmd.row_alpha = 1'b1;
      ST_ROW_MUL_B: cmd.row_beta = 1'b1;
      ST_FINISH: begin
        cmd.row_emit    = stat.out_free;
        cmd.row_advance = stat.out_free;
        cmd.last        = !(zw_r && stat.more_rows);
      end
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

// File: src/sell_datapath.sv
// ---------------------------------------------------------------------------
// sell_datapath
// Vector memories, configuration registers, chunk counters, shared
// multiplier, accumulator and the result output register.
// ---------------------------------------------------------------------------
`default_nettype none
module sell_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sell_pkg::cmd_t cmd,
  output sell_pkg::stat_t    stat,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [31:0]   cfg_data,
  input  wire logic [1:0]    in_func,
  input  wire logic [11:0]   in_load_index,
  input  wire logic signed [31:0] in_load_value,
  input  wire logic [11:0]   in_chunk_index,
  input  wire logic [7:0]    in_chunk_slots,
  input  wire logic signed [12:0] in_column,
  input  wire logic signed [31:0] in_entry_value,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic [11:0]        out_row_index,
  output logic signed [31:0] out_row_result,
  output logic               out_last
);
  import sell_pkg::*;

  // Configuration registers.
  logic signed [31:0] alpha_r, beta_r;
  logic [12:0]        rows_r;
  logic [5:0]         slice_r;

  // Chunk state.
  logic [16:0]        base_r;
  logic [4:0]         rin_r;
  logic [7:0]         slot_r;
  logic [7:0]         width_r;
  logic               open_r;
  logic signed [63:0] acc_r;

  // Latched item fields.
  logic [11:0]        cidx_r;
  logic [7:0]         cwidth_r;
  logic               col_ok_r;
  logic signed [31:0] val_r;

  // Memories and read data.
  logic signed [31:0] x_mem [VECTOR_DEPTH];
  logic signed [31:0] y_mem [VECTOR_DEPTH];
  logic signed [31:0] x_rd_r, y_rd_r;

  // Multiplier and row arithmetic.
  logic signed [63:0] prod_r, a_r;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] row_value;

  // Output register.
  logic               out_valid_r;
  logic [11:0]        out_row_r;
  logic signed [31:0] out_result_r;
  logic               out_last_r;

  logic [5:0]  slice_eff;
  logic [12:0] row_lim;
  logic [16:0] row_full;
  logic [17:0] row_next;
  logic [5:0]  rin_p1;
  logic [16:0] base_prod;

  // Effective slice height and row limit.
  always_comb begin
    if (slice_r == '0) begin
      slice_eff = 6'd1;
    end else if (slice_r > 6'(MAX_SLICE)) begin
      slice_eff = 6'(MAX_SLICE);
    end else begin
      slice_eff = slice_r;
    end
    row_lim = (rows_r > 13'(VECTOR_DEPTH)) ? 13'(VECTOR_DEPTH) : rows_r;
  end

  assign row_full  = base_r + {12'd0, rin_r};
  assign row_next  = {1'b0, row_full} + 18'd1;
  assign rin_p1    = {1'b0, rin_r} + 6'd1;
  assign base_prod = {5'd0, cidx_r} * {11'd0, slice_eff};

  // Status toward the controller.
  always_comb begin
    stat.chunk_is_open   = open_r;
    stat.base_past_limit = base_r >= {4'd0, row_lim};
    stat.width_zero      = (width_r == '0);
    stat.slot_end        = ({1'b0, slot_r} + 9'd1) >= {1'b0, width_r};
    stat.row_in_range    = row_full < {4'd0, row_lim};
    stat.more_rows       = !((rin_p1 >= slice_eff) || (row_next >= {5'd0, row_lim}));
    stat.out_free        = !out_valid_r || out_ready;
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= 32'sd65536;
      beta_r  <= '0;
      rows_r  <= '0;
      slice_r <= 6'd8;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ALPHA: alpha_r <= cfg_data;
        CFG_BETA:  beta_r  <= cfg_data;
        CFG_ROWS:  rows_r  <= cfg_data[12:0];
        CFG_SLICE: slice_r <= cfg_data[5:0];
        default:   ;
      endcase
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cidx_r   <= in_chunk_index;
      cwidth_r <= (in_chunk_slots > 8'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : in_chunk_slots;
      col_ok_r <= !in_column[12];
      val_r    <= in_entry_value;
    end
  end

  // x memory: loaded by items, read at the slot column on accept.
  always_ff @(posedge clk) begin
    if (cmd.accept && func_t'(in_func) == FUNC_LOAD_X) begin
      x_mem[in_load_index] <= in_load_value;
    end
    if (cmd.accept) begin
      x_rd_r <= x_mem[in_column[ADDR_W-1:0]];
    end
  end

  // y memory: loaded by items or written back with each row result.
  always_ff @(posedge clk) begin
    if (cmd.accept && func_t'(in_func) == FUNC_LOAD_Y) begin
      y_mem[in_load_index] <= in_load_value;
    end else if (cmd.row_emit) begin
      y_mem[row_full[ADDR_W-1:0]] <= row_value;
    end
    if (cmd.row_alpha) begin
      y_rd_r <= y_mem[row_full[ADDR_W-1:0]];
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    if (cmd.row_alpha) begin
      mul_a = alpha_r;
      mul_b = sat32(acc_r);
    end else if (cmd.row_beta) begin
      mul_a = beta_r;
      mul_b = y_rd_r;
    end else begin
      mul_a = val_r;
      mul_b = x_rd_r;
    end
  end

  // Product and rounded alpha term registers.
  always_ff @(posedge clk) begin
    if (cmd.slot_mul || cmd.row_alpha || cmd.row_beta) begin
      prod_r <= mul_a * mul_b;
    end
    if (cmd.row_beta) begin
      a_r <= round_q16(prod_r);
    end
  end

  assign row_value = sat32(a_r + round_q16(prod_r));

  // Chunk counters and accumulator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= '0;
      rin_r   <= '0;
      slot_r  <= '0;
      width_r <= '0;
      open_r  <= 1'b0;
      acc_r   <= '0;
    end else if (cmd.chunk_setup) begin
      base_r  <= base_prod;
      rin_r   <= '0;
      slot_r  <= '0;
      width_r <= cwidth_r;
      open_r  <= 1'b0;
      acc_r   <= '0;
    end else if (cmd.chunk_open) begin
      open_r <= 1'b1;
    end else if (cmd.row_advance) begin
      acc_r  <= '0;
      slot_r <= '0;
      if (stat.more_rows) begin
        rin_r <= rin_p1[4:0];
      end else begin
        rin_r  <= '0;
        open_r <= 1'b0;
      end
    end else if (cmd.slot_acc) begin
      slot_r <= slot_r + 8'd1;
      if (col_ok_r) begin
        acc_r <= acc_r + round_q16(prod_r);
      end
    end
  end

  // Result output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.row_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.row_emit) begin
      out_row_r    <= row_full[ADDR_W-1:0];
      out_result_r <= row_value;
      out_last_r   <= cmd.last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_row_index  = out_row_r;
  assign out_row_result = out_result_r;
  assign out_last       = out_last_r;

`ifndef NO_ASSERTIONS
  // A new result never overwrites one still waiting to be taken.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_emit |-> (!out_valid_r || out_ready))
    else $error("result overwritten while pending");

  // An open chunk always has a nonzero width.
  assert property (@(posedge clk) disable iff (!rst_n)
    open_r |-> (width_r != '0))
    else $error("open chunk with zero width");

  // Slots accumulate only into an open chunk.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.slot_acc |-> open_r)
    else $error("slot accumulated without open chunk");
`endif

endmodule
`default_nettype wire

// File: src/sliced_ell_spmv_engine.sv
// Sequencing: a load item is taken in idle; a chunk start runs setup and check,
// then row multiply A, B and finish per row of a zero-width chunk; a slot runs
// multiply and accumulate, then the row states when it ends a row, all through
// one shared 32x32 multiplier. Throughput: one item at a time, taken only in
// idle; a row waits in its finish state until the output register is free.
// Reset: synchronous active low; clears control state, memories stay undefined.
// ---------------------------------------------------------------------------
// sliced_ell_spmv_engine
// Sliced ELL sparse matrix-vector engine, y = alpha*A*x + beta*y in Q16.16.
// ---------------------------------------------------------------------------
`default_nettype none
module sliced_ell_spmv_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  sell_in_if.sink          in_chan,
  sell_out_if.source       out_chan,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import sell_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller.
  sell_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_func  (in_chan.func),
    .in_ready (in_chan.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath.
  sell_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_func        (in_chan.func),
    .in_load_index  (in_chan.load_index),
    .in_load_value  (in_chan.load_value),
    .in_chunk_index (in_chan.chunk_index),
    .in_chunk_slots (in_chan.chunk_slots),
    .in_column      (in_chan.column),
    .in_entry_value (in_chan.entry_value),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_row_index  (out_chan.row_index),
    .out_row_result (out_chan.row_result),
    .out_last       (out_chan.last)
  );

endmodule
`default_nettype wire
